// ===== sv/c_subset_lexer_defines.svh =====
// -----------------------------------------------------------------------------
// c_subset_lexer_defines: assertion macros shared by the lexer RTL
// All checks sample on clk_i and are off while rst_ni is low.
// -----------------------------------------------------------------------------
`ifndef C_SUBSET_LEXER_DEFINES_SVH
`define C_SUBSET_LEXER_DEFINES_SVH

// Same-cycle implication.
`define CSL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CSL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/csl_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// csl_pkg: shared types and constants of the C subset lexer
// Token kinds, byte classes, the queue item and the keyword lookup.
// -----------------------------------------------------------------------------
package csl_pkg;

  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);
  localparam int KW_BYTES = 6;

  localparam logic [15:0] LINE_MAX = 16'hFFFF;
  localparam logic [11:0] COL_MAX  = 12'hFFF;
  localparam logic [11:0] LEN_MAX  = 12'hFFF;
  localparam logic [19:0] OFF_MAX  = 20'hFFFFF;

  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  typedef enum logic [3:0] {
    TK_END    = 4'd0,
    TK_IDENT  = 4'd1,
    TK_NUMBER = 4'd2,
    TK_PLUS   = 4'd3,
    TK_MINUS  = 4'd4,
    TK_STAR   = 4'd5,
    TK_SLASH  = 4'd6,
    TK_SEMI   = 4'd7,
    TK_LPAREN = 4'd8,
    TK_RPAREN = 4'd9,
    TK_LBRACE = 4'd10,
    TK_RBRACE = 4'd11,
    TK_INT    = 4'd12,
    TK_VOID   = 4'd13,
    TK_IF     = 4'd14,
    TK_RETURN = 4'd15
  } kind_e;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_LETTER,
    CLS_DIGIT,
    CLS_SYMBOL,
    CLS_NEWLINE,
    CLS_END
  } cls_e;

  typedef struct packed {
    logic [7:0] ch;
    cls_e       cls;
    kind_e      sym;
  } item_t;

  // Keyword match on the first bytes of an identifier and its full length.
  function automatic kind_e ident_kind(input logic [KW_BYTES-1:0][7:0] p,
                                       input logic [11:0] len);
    kind_e k;
    k = TK_IDENT;
    if (len == 12'd3 && p[0] == "i" && p[1] == "n" && p[2] == "t") begin
      k = TK_INT;
    end else if (len == 12'd4 && p[0] == "v" && p[1] == "o" && p[2] == "i" &&
                 p[3] == "d") begin
      k = TK_VOID;
    end else if (len == 12'd2 && p[0] == "i" && p[1] == "f") begin
      k = TK_IF;
    end else if (len == 12'd6 && p[0] == "r" && p[1] == "e" && p[2] == "t" &&
                 p[3] == "u" && p[4] == "r" && p[5] == "n") begin
      k = TK_RETURN;
    end
    return k;
  endfunction

endpackage

// ===== sv/csl_if.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// csl_if: valid/ready channels of the lexer
// Source bytes in, tokens out.
// -----------------------------------------------------------------------------
interface csl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface csl_tok_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] line;
  logic [11:0] column;
  logic [19:0] start_offset;
  logic [11:0] length;
  logic        last;

  modport source (output valid, output token_kind, output line, output column,
                  output start_offset, output length, output last, input ready);
  modport sink   (input valid, input token_kind, input line, input column,
                  input start_offset, input length, input last, output ready);
endinterface

// ===== sv/csl_front.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// csl_front: byte intake and classification
// Registers each accepted byte with its class and symbol kind.
// -----------------------------------------------------------------------------
module csl_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  csl_byte_if.sink        byte_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output csl_pkg::item_t  push_item_o
);

  logic           valid_q, valid_d;
  csl_pkg::item_t item_q, item_d;
  csl_pkg::item_t cls_item;

  always_comb begin
    cls_item.ch  = byte_i.ch;
    cls_item.cls = csl_pkg::CLS_OTHER;
    cls_item.sym = csl_pkg::TK_END;
    case (byte_i.ch)
      "+": cls_item.sym = csl_pkg::TK_PLUS;
      "-": cls_item.sym = csl_pkg::TK_MINUS;
      "*": cls_item.sym = csl_pkg::TK_STAR;
      "/": cls_item.sym = csl_pkg::TK_SLASH;
      ";": cls_item.sym = csl_pkg::TK_SEMI;
      "(": cls_item.sym = csl_pkg::TK_LPAREN;
      ")": cls_item.sym = csl_pkg::TK_RPAREN;
      "{": cls_item.sym = csl_pkg::TK_LBRACE;
      "}": cls_item.sym = csl_pkg::TK_RBRACE;
      default: cls_item.sym = csl_pkg::TK_END;
    endcase
    if (byte_i.ch inside {["a":"z"], ["A":"Z"], csl_pkg::CH_UNDERSCORE}) begin
      cls_item.cls = csl_pkg::CLS_LETTER;
    end else if (byte_i.ch inside {["0":"9"]}) begin
      cls_item.cls = csl_pkg::CLS_DIGIT;
    end else if (byte_i.ch == csl_pkg::CH_NEWLINE) begin
      cls_item.cls = csl_pkg::CLS_NEWLINE;
    end else if (byte_i.ch == csl_pkg::CH_NUL) begin
      cls_item.cls = csl_pkg::CLS_END;
    end else if (cls_item.sym != csl_pkg::TK_END) begin
      cls_item.cls = csl_pkg::CLS_SYMBOL;
    end
  end

  assign byte_i.ready = !valid_q || push_ready_i;
  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (byte_i.ready) begin
      valid_d = byte_i.valid;
      item_d  = cls_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

// ===== sv/csl_queue.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// csl_queue: short item queue between front and back
// Lets the front keep taking bytes while the back waits on the token port.
// -----------------------------------------------------------------------------
module csl_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  csl_pkg::item_t  push_item_i,
  output logic            head_valid_o,
  output csl_pkg::item_t  head_o,
  input  logic            pop_i
);

  csl_pkg::item_t                mem_q [csl_pkg::Q_DEPTH];
  logic [csl_pkg::Q_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [csl_pkg::Q_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [csl_pkg::Q_CNT_W-1:0]   count_q, count_d;
  logic                          push, pop;

  assign push_ready_o = count_q != csl_pkg::Q_CNT_W'(csl_pkg::Q_DEPTH);
  assign head_valid_o = count_q != '0;
  assign head_o       = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== sv/csl_back.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// csl_back: token scanner and output register
// Tracks position and the pending token; a byte that closes a token and is
// itself a symbol or end of text sends two tokens, the closed token first.
// -----------------------------------------------------------------------------
`include "c_subset_lexer_defines.svh"

module csl_back #(
  parameter int KeywordPrefix = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  csl_pkg::item_t  head_i,
  output logic            pop_o,
  csl_tok_if.source       tok_o
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER
  } mode_e;

  mode_e          mode_q, mode_d;
  logic [15:0]    cur_line_q, cur_line_d;
  logic [11:0]    cur_col_q, cur_col_d;
  logic [19:0]    cur_off_q, cur_off_d;
  logic [15:0]    tok_line_q, tok_line_d;
  logic [11:0]    tok_col_q, tok_col_d;
  logic [19:0]    tok_off_q, tok_off_d;
  logic [11:0]    tok_len_q, tok_len_d;
  logic [7:0]     prefix_q [KeywordPrefix];
  logic [7:0]     prefix_d [KeywordPrefix];
  logic           sent_first_q, sent_first_d;

  logic           out_valid_q, out_valid_d;
  csl_pkg::kind_e out_kind_q, out_kind_d;
  logic [15:0]    out_line_q, out_line_d;
  logic [11:0]    out_col_q, out_col_d;
  logic [19:0]    out_off_q, out_off_d;
  logic [11:0]    out_len_q, out_len_d;
  logic           out_last_q, out_last_d;

  logic [csl_pkg::KW_BYTES-1:0][7:0] kw_pre;
  csl_pkg::kind_e flush_kind;
  logic           is_letter, is_digit, is_end, is_sym;
  logic           cont, flush, second, has_out, use_first, out_free, load, pop;

  always_comb begin
    for (int i = 0; i < csl_pkg::KW_BYTES; i++) begin
      kw_pre[i] = prefix_q[i];
    end
    flush_kind = (mode_q == MODE_NUMBER) ? csl_pkg::TK_NUMBER
                                         : csl_pkg::ident_kind(kw_pre, tok_len_q);

    is_letter = head_i.cls == csl_pkg::CLS_LETTER;
    is_digit  = head_i.cls == csl_pkg::CLS_DIGIT;
    is_end    = head_i.cls == csl_pkg::CLS_END;
    is_sym    = head_i.cls == csl_pkg::CLS_SYMBOL;

    case (mode_q)
      MODE_IDENT:  cont = is_letter || is_digit;
      MODE_NUMBER: cont = is_digit;
      default:     cont = 1'b0;
    endcase
    flush     = (mode_q != MODE_IDLE) && !cont;
    second    = is_end || is_sym;
    has_out   = flush || second;
    use_first = flush && !sent_first_q;
    out_free  = !out_valid_q || tok_o.ready;
    load      = head_valid_i && has_out && out_free;
    // hold the byte while its first of two tokens goes out
    pop       = head_valid_i && (!has_out || (out_free && !(use_first && second)));
  end

  assign pop_o = pop;

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_line_d  = out_line_q;
    out_col_d   = out_col_q;
    out_off_d   = out_off_q;
    out_len_d   = out_len_q;
    out_last_d  = out_last_q;
    if (load) begin
      out_valid_d = 1'b1;
      if (use_first) begin
        out_kind_d = flush_kind;
        out_line_d = tok_line_q;
        out_col_d  = tok_col_q;
        out_off_d  = tok_off_q;
        out_len_d  = tok_len_q;
        out_last_d = !second;
      end else begin
        out_kind_d = is_end ? csl_pkg::TK_END : head_i.sym;
        out_line_d = cur_line_q;
        out_col_d  = cur_col_q;
        out_off_d  = cur_off_q;
        out_len_d  = is_end ? 12'd0 : 12'd1;
        out_last_d = 1'b1;
      end
    end else if (tok_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Scanner state
  always_comb begin
    mode_d     = mode_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    cur_off_d  = cur_off_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    tok_off_d  = tok_off_q;
    tok_len_d  = tok_len_q;
    for (int i = 0; i < KeywordPrefix; i++) begin
      prefix_d[i] = prefix_q[i];
    end
    sent_first_d = pop ? 1'b0 : (load ? 1'b1 : sent_first_q);

    if (pop) begin
      if (is_end) begin
        // end of text: start over for the next text
        mode_d     = MODE_IDLE;
        cur_line_d = 16'd1;
        cur_col_d  = 12'd1;
        cur_off_d  = '0;
        tok_line_d = 16'd1;
        tok_col_d  = 12'd1;
        tok_off_d  = '0;
        tok_len_d  = '0;
        for (int i = 0; i < KeywordPrefix; i++) begin
          prefix_d[i] = '0;
        end
      end else begin
        if (cont) begin
          for (int i = 0; i < KeywordPrefix; i++) begin
            if (tok_len_q == 12'(i)) begin
              prefix_d[i] = head_i.ch;
            end
          end
          if (tok_len_q != csl_pkg::LEN_MAX) begin
            tok_len_d = tok_len_q + 12'd1;
          end
        end else if (is_letter || is_digit) begin
          mode_d     = is_letter ? MODE_IDENT : MODE_NUMBER;
          tok_line_d = cur_line_q;
          tok_col_d  = cur_col_q;
          tok_off_d  = cur_off_q;
          tok_len_d  = 12'd1;
          for (int i = 0; i < KeywordPrefix; i++) begin
            prefix_d[i] = (i == 0) ? head_i.ch : 8'h00;
          end
        end else begin
          mode_d = MODE_IDLE;
        end

        if (head_i.cls == csl_pkg::CLS_NEWLINE) begin
          if (cur_line_q != csl_pkg::LINE_MAX) begin
            cur_line_d = cur_line_q + 16'd1;
          end
          cur_col_d = 12'd1;
        end else if (cur_col_q != csl_pkg::COL_MAX) begin
          cur_col_d = cur_col_q + 12'd1;
        end
        if (cur_off_q != csl_pkg::OFF_MAX) begin
          cur_off_d = cur_off_q + 20'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      cur_line_q   <= 16'd1;
      cur_col_q    <= 12'd1;
      cur_off_q    <= '0;
      tok_line_q   <= 16'd1;
      tok_col_q    <= 12'd1;
      tok_off_q    <= '0;
      tok_len_q    <= '0;
      for (int i = 0; i < KeywordPrefix; i++) begin
        prefix_q[i] <= '0;
      end
      sent_first_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= csl_pkg::TK_END;
      out_line_q   <= '0;
      out_col_q    <= '0;
      out_off_q    <= '0;
      out_len_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      cur_line_q   <= cur_line_d;
      cur_col_q    <= cur_col_d;
      cur_off_q    <= cur_off_d;
      tok_line_q   <= tok_line_d;
      tok_col_q    <= tok_col_d;
      tok_off_q    <= tok_off_d;
      tok_len_q    <= tok_len_d;
      for (int i = 0; i < KeywordPrefix; i++) begin
        prefix_q[i] <= prefix_d[i];
      end
      sent_first_q <= sent_first_d;
      out_valid_q  <= out_valid_d;
      out_kind_q   <= out_kind_d;
      out_line_q   <= out_line_d;
      out_col_q    <= out_col_d;
      out_off_q    <= out_off_d;
      out_len_q    <= out_len_d;
      out_last_q   <= out_last_d;
    end
  end

  assign tok_o.valid        = out_valid_q;
  assign tok_o.token_kind   = out_kind_q;
  assign tok_o.line         = out_line_q;
  assign tok_o.column       = out_col_q;
  assign tok_o.start_offset = out_off_q;
  assign tok_o.length       = out_len_q;
  assign tok_o.last         = out_last_q;

  `CSL_ASSERT_IMP(a_first_keeps_head, sent_first_q, head_valid_i, "byte left queue mid pair")
  `CSL_ASSERT_IMP(a_pending_has_len, mode_q != MODE_IDLE, tok_len_q != 12'd0, "empty token pending")
  `CSL_ASSERT_IMP(a_end_is_last, out_valid_q && out_kind_q == csl_pkg::TK_END, out_last_q, "end token not last")
  `CSL_ASSERT_IMP(a_first_not_last, $rose(sent_first_q), out_valid_q && !out_last_q, "first of pair marked last")

endmodule

// ===== sv/c_subset_lexer.sv =====
`timescale 1ns / 1ps
// Path: a byte passes the front register and the queue, then its token is registered in the output register.
// Throughput: one byte per cycle while the token port takes tokens; a byte that both closes a token and is a
// symbol or end of text holds the scanner until both of its tokens are sent.
// A four-entry queue between classifier and scanner absorbs output stalls.
// Reset (rst_ni low, asynchronous): line 1, column 1, offset 0, queue empty.
// -----------------------------------------------------------------------------
// c_subset_lexer: streaming tokenizer for a small C subset
// Front classifies bytes, a queue decouples it, the back scans and emits tokens.
// -----------------------------------------------------------------------------
module c_subset_lexer #(
  parameter int KEYWORD_PREFIX = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  csl_byte_if.sink   byte_i,
  csl_tok_if.source  tok_o
);

  logic           push_valid, push_ready;
  csl_pkg::item_t push_item;
  logic           head_valid, pop;
  csl_pkg::item_t head;

  csl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  csl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  csl_back #(
    .KeywordPrefix (KEYWORD_PREFIX)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .tok_o        (tok_o)
  );

endmodule

// ===== verif/c_subset_lexer_test.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// c_subset_lexer_test: self-checking bench for the C subset lexer
// Feeds byte streams (short directed texts and random token-shaped texts with
// noise) with random gaps and output stalls. Expected tokens come from a
// behavioral scanner, and each accepted token is compared field by field in order.
// -----------------------------------------------------------------------------
module c_subset_lexer_test;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_IDENT,
    SCAN_NUMBER
  } scan_e;

  typedef struct {
    csl_pkg::kind_e kind;
    logic [15:0]    line;
    logic [11:0]    column;
    logic [19:0]    offset;
    logic [11:0]    length;
    logic           last;
  } token_t;

  typedef struct {
    logic [7:0]  ch;
    int unsigned gap;
  } src_byte_t;

  localparam string WORD_CHARS  =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  localparam string SYMBOLS     = "+-*/;(){}";

  logic clk_i;
  logic rst_ni;

  csl_byte_if src_bus ();
  csl_tok_if  tok_bus ();

  c_subset_lexer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (src_bus),
    .tok_o  (tok_bus)
  );

  string          keywords[4]      = '{"int", "void", "if", "return"};
  csl_pkg::kind_e keyword_kinds[4] = '{csl_pkg::TK_INT, csl_pkg::TK_VOID, csl_pkg::TK_IF,
                                       csl_pkg::TK_RETURN};

  // Scanner state of the expected behavior.
  scan_e       lex_mode;
  logic [15:0] pos_line;
  logic [11:0] pos_col;
  logic [19:0] pos_off;
  logic [15:0] word_line;
  logic [11:0] word_col;
  logic [19:0] word_off;
  logic [11:0] word_len;
  logic [7:0]  word_head [csl_pkg::KW_BYTES];

  token_t      tokens_due[$];
  src_byte_t   pending[$];
  int unsigned total_bytes;
  int unsigned bytes_fed;
  int unsigned bytes_taken;
  int unsigned tokens_taken;
  int unsigned tokens_seen;
  int unsigned errors;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          gap_drawn;
  bit          src_calm;
  bit          sink_calm;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit is_word_start(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           c == csl_pkg::CH_UNDERSCORE;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic csl_pkg::kind_e symbol_of(input logic [7:0] c);
    csl_pkg::kind_e k;
    case (c)
      "+": k = csl_pkg::TK_PLUS;
      "-": k = csl_pkg::TK_MINUS;
      "*": k = csl_pkg::TK_STAR;
      "/": k = csl_pkg::TK_SLASH;
      ";": k = csl_pkg::TK_SEMI;
      "(": k = csl_pkg::TK_LPAREN;
      ")": k = csl_pkg::TK_RPAREN;
      "{": k = csl_pkg::TK_LBRACE;
      "}": k = csl_pkg::TK_RBRACE;
      default: k = csl_pkg::TK_END;
    endcase
    return k;
  endfunction

  // A word is a keyword only on full length and matching head bytes.
  function automatic csl_pkg::kind_e word_kind();
    csl_pkg::kind_e k;
    bit             same;
    k = csl_pkg::TK_IDENT;
    foreach (keywords[i]) begin
      if (word_len == keywords[i].len()) begin
        same = 1'b1;
        for (int j = 0; j < keywords[i].len(); j++) begin
          if (word_head[j] != keywords[i][j]) same = 1'b0;
        end
        if (same) k = keyword_kinds[i];
      end
    end
    return k;
  endfunction

  function automatic token_t make_token(input csl_pkg::kind_e k, input logic [15:0] ln,
                                        input logic [11:0] col,
                                        input logic [19:0] off,
                                        input logic [11:0] len);
    token_t t;
    t.kind   = k;
    t.line   = ln;
    t.column = col;
    t.offset = off;
    t.length = len;
    t.last   = 1'b0;
    return t;
  endfunction

  task automatic clear_lexer();
    lex_mode  = SCAN_IDLE;
    pos_line  = 16'd1;
    pos_col   = 12'd1;
    pos_off   = 20'd0;
    word_line = 16'd1;
    word_col  = 12'd1;
    word_off  = 20'd0;
    word_len  = 12'd0;
    foreach (word_head[i]) word_head[i] = 8'd0;
  endtask

  // Advance the scanner by one byte and queue the tokens it produces.
  task automatic lex_byte(input logic [7:0] c);
    token_t         found [2];
    int             n;
    bit             grows;
    csl_pkg::kind_e sk;
    n = 0;
    grows = (lex_mode == SCAN_IDENT && (is_word_start(c) || is_digit(c))) ||
            (lex_mode == SCAN_NUMBER && is_digit(c));
    if (lex_mode != SCAN_IDLE && !grows) begin
      found[n] = make_token(lex_mode == SCAN_NUMBER ? csl_pkg::TK_NUMBER : word_kind(),
                            word_line, word_col, word_off, word_len);
      n++;
      lex_mode = SCAN_IDLE;
    end
    if (c == csl_pkg::CH_NUL) begin
      found[n] = make_token(csl_pkg::TK_END, pos_line, pos_col, pos_off, 12'd0);
      n++;
      clear_lexer();
    end else begin
      if (grows) begin
        if (word_len < csl_pkg::KW_BYTES) word_head[word_len] = c;
        if (word_len < csl_pkg::LEN_MAX) word_len++;
      end else if (is_word_start(c) || is_digit(c)) begin
        lex_mode  = is_digit(c) ? SCAN_NUMBER : SCAN_IDENT;
        word_line = pos_line;
        word_col  = pos_col;
        word_off  = pos_off;
        word_len  = 12'd1;
        foreach (word_head[i]) word_head[i] = 8'd0;
        word_head[0] = c;
      end else begin
        sk = symbol_of(c);
        if (sk != csl_pkg::TK_END) begin
          found[n] = make_token(sk, pos_line, pos_col, pos_off, 12'd1);
          n++;
        end
      end
      if (c == csl_pkg::CH_NEWLINE) begin
        if (pos_line < csl_pkg::LINE_MAX) pos_line++;
        pos_col = 12'd1;
      end else if (pos_col < csl_pkg::COL_MAX) begin
        pos_col++;
      end
      if (pos_off < csl_pkg::OFF_MAX) pos_off++;
    end
    for (int i = 0; i < n; i++) begin
      found[i].last = (i == n - 1);
      tokens_due.push_back(found[i]);
    end
  endtask

  task automatic check_field(input string name, input logic [19:0] want,
                             input logic [19:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic put_byte(input logic [7:0] c);
    src_byte_t b;
    if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
    b.ch  = c;
    b.gap = draw_wait(src_calm);
    pending.push_back(b);
  endtask

  task automatic put_text(input string s);
    foreach (s[i]) put_byte(s[i]);
  endtask

  function automatic logic [7:0] any_word_char();
    return WORD_CHARS[$urandom_range(0, WORD_CHARS.len() - 1)];
  endfunction

  // Letter or underscore first, then word characters.
  task automatic put_word(input int len);
    put_byte(WORD_CHARS[$urandom_range(0, 52)]);
    for (int i = 1; i < len; i++) put_byte(any_word_char());
  endtask

  // One random text: token-shaped pieces with noise, closed by a NUL.
  task automatic put_random_text();
    int    pieces;
    string kw;
    pieces = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 30);
    for (int p = 0; p < pieces; p++) begin
      kw = keywords[$urandom_range(0, 3)];
      case ($urandom_range(0, 11))
        0, 1: put_text(kw);
        2: begin
          // near miss: cut short or run on
          if ($urandom_range(0, 1) == 0) put_text(kw.substr(0, kw.len() - 2));
          else begin
            put_text(kw);
            put_byte(any_word_char());
          end
        end
        3: put_word($urandom_range(1, 12));
        4: begin
          for (int i = $urandom_range(1, 6); i > 0; i--) begin
            put_byte(8'("0" + $urandom_range(0, 9)));
          end
          if ($urandom_range(0, 2) == 0) put_word($urandom_range(1, 4));
        end
        5, 6: put_byte(SYMBOLS[$urandom_range(0, SYMBOLS.len() - 1)]);
        7, 8: put_byte(" ");
        9: put_byte($urandom_range(0, 1) ? "\t" : "\r");
        10: put_byte(csl_pkg::CH_NEWLINE);
        default: put_byte(8'($urandom_range(1, 255)));
      endcase
    end
    put_byte(csl_pkg::CH_NUL);
  endtask

  // Hold valid until the item is taken, then wait out the next item's gap.
  always @(negedge clk_i) begin
    src_byte_t nxt;
    logic      go;
    go = src_bus.valid;
    if (go && bytes_taken == bytes_fed) go = 1'b0;
    if (rst_ni && !go && pending.size() > 0) begin
      if (!gap_drawn) begin
        gap_left  = pending[0].gap;
        gap_drawn = 1'b1;
      end
      if (gap_left == 0) begin
        nxt = pending.pop_front();
        src_bus.ch <= nxt.ch;
        bytes_fed++;
        gap_drawn = 1'b0;
        go = 1'b1;
      end else begin
        gap_left--;
      end
    end
    src_bus.valid <= go;
  end

  // Stall the token side for a fresh random count after each accepted token.
  always @(negedge clk_i) begin
    if (tokens_taken != tokens_seen) begin
      tokens_seen = tokens_taken;
      if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
      stall_left = draw_wait(sink_calm);
    end
    if (stall_left > 0) begin
      tok_bus.ready <= 1'b0;
      stall_left--;
    end else begin
      tok_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    token_t want;
    if (rst_ni) begin
      if (tok_bus.valid && tok_bus.ready) begin
        tokens_taken++;
        if (tokens_due.size() == 0) begin
          errors++;
          $error("token_kind: expected none, got %0d at line %0d column %0d",
                 tok_bus.token_kind, tok_bus.line, tok_bus.column);
        end else begin
          want = tokens_due.pop_front();
          check_field("token_kind", 20'(want.kind), 20'(tok_bus.token_kind));
          check_field("line", 20'(want.line), 20'(tok_bus.line));
          check_field("column", 20'(want.column), 20'(tok_bus.column));
          check_field("start_offset", want.offset, tok_bus.start_offset);
          check_field("length", 20'(want.length), 20'(tok_bus.length));
          check_field("last", 20'(want.last), 20'(tok_bus.last));
        end
      end
      // Predict after the compare: a byte's tokens never show on its own edge.
      if (src_bus.valid && src_bus.ready) begin
        bytes_taken++;
        lex_byte(src_bus.ch);
      end
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    src_bus.valid = 1'b0;
    src_bus.ch    = 8'd0;
    tok_bus.ready = 1'b0;
    bytes_fed     = 0;
    bytes_taken   = 0;
    tokens_taken  = 0;
    tokens_seen   = 0;
    errors        = 0;
    gap_left      = 0;
    stall_left    = 0;
    gap_drawn     = 1'b0;
    src_calm      = 1'b0;
    sink_calm     = 1'b0;
    clear_lexer();

    // Directed: empty text, all kinds, number then letter, skipped bytes,
    // number pending at end of text.
    put_byte(csl_pkg::CH_NUL);
    put_text("int(void){if 9a;return-x+1*2/_}");
    put_text("\n\t\r");
    put_byte(8'hFF);
    put_text("7");
    put_byte(csl_pkg::CH_NUL);

    while (pending.size() < 1360) put_random_text();

    put_text("if;");
    put_byte(csl_pkg::CH_NUL);
    total_bytes = pending.size();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_taken < total_bytes || tokens_due.size() > 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/csl_pkg.sv
sv/csl_if.sv
sv/csl_front.sv
sv/csl_queue.sv
sv/csl_back.sv
sv/c_subset_lexer.sv
verif/c_subset_lexer_test.sv
